// ----- src/hds_pkg.sv -----
// Shared widths, register indexes and the per-word tag type for the heat
// diffusion stencil block. No dependencies.
package hds_pkg;

  localparam int VAL_W  = 15;   // unsigned Q7.8 cell value
  localparam int POS_W  = 5;    // row and column index
  localparam int GS_W   = 6;    // grid_size register
  localparam int PHI_W  = 15;   // phi_coeff register, Q0.16
  localparam int LAP_W  = 18;   // signed five-point laplacian
  localparam int PROD_W = 34;   // signed phi * laplacian
  localparam int SUM_W  = 36;   // signed pre-round accumulator
  localparam int CFG_IW = 1;    // configuration register index width

  localparam logic [CFG_IW-1:0] REG_GRID_SIZE = 1'd0;
  localparam logic [CFG_IW-1:0] REG_PHI_COEFF = 1'd1;

  localparam logic [GS_W-1:0]  GRID_SIZE_RST = 6'd10;
  localparam logic [PHI_W-1:0] PHI_COEFF_RST = 15'd15729;
  localparam logic [GS_W-1:0]  GRID_MIN      = 6'd3;

  localparam logic [1:0] BANK_0 = 2'd0;
  localparam logic [1:0] BANK_1 = 2'd1;
  localparam logic [1:0] BANK_2 = 2'd2;

  // Travels with every word through the pipeline.
  typedef struct packed {
    logic             emit;   // word produces a result
    logic             pass;   // edge cell: value passes unchanged
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;   // last result caused by its input word
    logic             done;   // final cell of the grid
  } tag_t;

endpackage

// ----- src/heat_diffusion_stencil_pass_top.sv -----
// Five-point heat diffusion stencil, one explicit time step per grid pass.
// Depends on hds_pkg for widths, register indexes and the tag type.
//
// Usage:
//   s_axis carries old cell values in raster order, one word per cell.
//   m_axis carries the updated cells: tdata = {col, row, value}, tlast marks
//   the last result caused by an input word, tuser marks the final cell.
//   Cell (r-1, c) comes out for input cell (r, c); the first row gives no
//   results. The last input of the grid also emits the whole last row.
//   Configure through cfg_wr_en/cfg_index/cfg_data only while idle; a write
//   of grid_size restarts the pass at cell (0, 0).
// Throughput: one word per cycle while m_axis accepts. After the last cell of a
//   grid the block reads the last row back from line memory and holds
//   s_axis_tready low until that row has been read.
// Pipeline: memory read, laplacian, multiply, then round/saturate into the
//   output register.
// The three line buffers share one memory with one write and two read
//   ports; row roles rotate through bank pointers instead of copying.
// Stall: a register plus skid output stage; the pipeline keeps going until
//   a result lands in the skid entry, then all stages hold.
// Reset: clears counters, bank pointers, valids and restores the register
//   defaults; line memory contents stay undefined until written.
module heat_diffusion_stencil_pass_top
  import hds_pkg::*;
#(
  parameter int MAX_GRID = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [PHI_W-1:0]  cfg_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [14:0] cell_value
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [14:0] new_value, [19:15] out_row,
                                            // [24:20] out_col
  output logic              m_axis_tlast,   // last_of_run
  output logic              m_axis_tuser    // grid_done
);

  localparam int LIM   = (MAX_GRID < 32) ? MAX_GRID : 32;
  localparam int AW    = $clog2(LIM);
  localparam int DEPTH = 4 << AW;

  // configuration
  logic [GS_W-1:0]  grid_size;
  logic [PHI_W-1:0] phi_coeff;

  // position and row bank pointers
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] col_count;
  logic [1:0]       in_bank;
  logic [1:0]       mid_bank;
  logic [1:0]       ab_bank;
  logic             flushing;
  logic [POS_W-1:0] fcol;

  // line memory
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;

  // stage B: read data present
  logic             b_vld;
  tag_t             b_tag;
  logic             b_use_a;
  logic [VAL_W-1:0] b_dn;
  logic [VAL_W-1:0] m0;      // middle row, column c-1
  logic [VAL_W-1:0] m1;      // middle row, column c

  // stage C: laplacian
  logic                    c_vld;
  tag_t                    c_tag;
  logic [VAL_W-1:0]        c_mid;
  logic signed [LAP_W-1:0] c_lap;

  // stage D: product
  logic                     d_vld;
  tag_t                     d_tag;
  logic [VAL_W-1:0]         d_mid;
  logic signed [PROD_W-1:0] d_prod;

  // output register and skid
  logic             o_vld;
  tag_t             o_tag;
  logic [VAL_W-1:0] o_val;
  logic             s_vld;
  tag_t             s_tag;
  logic [VAL_W-1:0] s_val;

  // combinational
  logic [GS_W-1:0]  n_eff;
  logic [POS_W-1:0] n_m1;
  logic [POS_W-1:0] rr;
  logic [POS_W-1:0] cc;
  logic [POS_W-1:0] cc_nxt;
  logic             pipe_go;
  logic             accept;
  logic             flush_go;
  logic             rd_en;
  logic             row_end;
  logic             grid_end;
  logic [AW+1:0]    addr_a;
  logic [AW+1:0]    addr_b;
  logic [AW+1:0]    addr_w;
  tag_t             a_tag;
  logic [VAL_W-1:0] b_mid;
  logic [VAL_W+1:0] nb_sum;
  logic signed [SUM_W-1:0] t_sum;
  logic [VAL_W-1:0] d_val;
  logic             d_new;

  // Clamp the grid size to the supported range.
  always_comb begin
    if (grid_size < GRID_MIN) begin
      n_eff = GRID_MIN;
    end else if (grid_size > GS_W'(LIM)) begin
      n_eff = GS_W'(LIM);
    end else begin
      n_eff = grid_size;
    end
    n_m1 = POS_W'(n_eff - 6'd1);
  end

  // Restart at the origin if the counters ever fall outside the grid.
  always_comb begin
    if ({1'b0, row_count} >= n_eff || {1'b0, col_count} >= n_eff) begin
      rr = '0;
      cc = '0;
    end else begin
      rr = row_count;
      cc = col_count;
    end
    row_end  = (cc == n_m1);
    grid_end = row_end && (rr == n_m1);
    cc_nxt   = row_end ? cc : cc + 5'd1;
  end

  assign pipe_go       = !s_vld;
  assign s_axis_tready = pipe_go && !flushing;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign flush_go      = flushing && pipe_go;
  assign rd_en         = accept || flush_go;

  // Port A: above row at c, or middle row at column 0, or the flush column.
  // Port B: middle row one column ahead.
  always_comb begin
    if (flushing) begin
      addr_a = {in_bank, AW'(fcol)};
    end else if (cc == '0) begin
      addr_a = {mid_bank, AW'(cc)};
    end else begin
      addr_a = {ab_bank, AW'(cc)};
    end
    addr_b = {mid_bank, AW'(cc_nxt)};
    addr_w = {in_bank, AW'(cc)};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[addr_w] <= s_axis_tdata[VAL_W-1:0];
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // Tag for the word entering stage B.
  always_comb begin
    if (flushing) begin
      a_tag.emit = 1'b1;
      a_tag.pass = 1'b1;
      a_tag.row  = n_m1;
      a_tag.col  = fcol;
      a_tag.last = (fcol == n_m1);
      a_tag.done = (fcol == n_m1);
    end else begin
      a_tag.emit = (rr != '0);
      a_tag.pass = (rr == 5'd1) || (cc == '0) || row_end;
      a_tag.row  = rr - 5'd1;
      a_tag.col  = cc;
      a_tag.last = !grid_end;
      a_tag.done = 1'b0;
    end
  end

  // Configuration, counters, bank rotation and last-row flush.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RST;
      phi_coeff <= PHI_COEFF_RST;
      row_count <= '0;
      col_count <= '0;
      in_bank   <= BANK_0;
      mid_bank  <= BANK_1;
      ab_bank   <= BANK_2;
      flushing  <= 1'b0;
      fcol      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_SIZE: begin
          grid_size <= cfg_data[GS_W-1:0];
          row_count <= '0;
          col_count <= '0;
        end
        REG_PHI_COEFF: phi_coeff <= cfg_data;
        default: ;
      endcase
    end else if (flush_go) begin
      fcol <= fcol + 5'd1;
      if (fcol == n_m1) begin
        flushing <= 1'b0;
      end
    end else if (accept) begin
      if (grid_end) begin
        row_count <= '0;
        col_count <= '0;
        flushing  <= 1'b1;
        fcol      <= '0;
      end else if (row_end) begin
        // rotate: incoming becomes middle, middle becomes above
        ab_bank   <= mid_bank;
        mid_bank  <= in_bank;
        in_bank   <= ab_bank;
        row_count <= rr + 5'd1;
        col_count <= '0;
      end else begin
        row_count <= rr;
        col_count <= cc + 5'd1;
      end
    end
  end

  // Stage B: hold read data alongside the word, track the middle-row taps.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (pipe_go) begin
      b_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_go && rd_en) begin
      b_tag   <= a_tag;
      b_use_a <= flushing || (cc == '0);
      b_dn    <= s_axis_tdata[VAL_W-1:0];
    end
    if (pipe_go && b_vld) begin
      m0 <= b_use_a ? rd_a : m1;
      m1 <= rd_b;
    end
  end

  assign b_mid  = b_use_a ? rd_a : m1;
  assign nb_sum = {2'b0, rd_a} + {2'b0, b_dn} + {2'b0, m0} + {2'b0, rd_b};

  // Stage C: laplacian.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (pipe_go) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_go && b_vld) begin
      c_tag <= b_tag;
      c_mid <= b_mid;
      c_lap <= $signed({1'b0, nb_sum}) - $signed({1'b0, b_mid, 2'b00});
    end
  end

  // Stage D: phi times laplacian.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (pipe_go) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_go && c_vld) begin
      d_tag  <= c_tag;
      d_mid  <= c_mid;
      d_prod <= $signed({1'b0, phi_coeff}) * c_lap;
    end
  end

  // Round half up, drop 16 fraction bits, saturate to 0..32767; edge cells pass unchanged.
  always_comb begin
    t_sum = $signed({5'b0, d_mid, 16'b0}) + SUM_W'(d_prod) + 36'sd32768;
    if (d_tag.pass) begin
      d_val = d_mid;
    end else if (t_sum[SUM_W-1]) begin
      d_val = '0;
    end else if (|t_sum[SUM_W-2:31]) begin
      d_val = '1;
    end else begin
      d_val = t_sum[30:16];
    end
    d_new = pipe_go && d_vld && d_tag.emit;
  end

  // Output register with skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
      s_vld <= 1'b0;
    end else if (o_vld && m_axis_tready) begin
      if (s_vld) begin
        s_vld <= 1'b0;
      end else begin
        o_vld <= d_new;
      end
    end else if (!o_vld) begin
      o_vld <= d_new;
    end else if (d_new) begin
      s_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_vld && m_axis_tready && s_vld) begin
      o_tag <= s_tag;
      o_val <= s_val;
    end else if ((!o_vld || m_axis_tready) && d_new) begin
      o_tag <= d_tag;
      o_val <= d_val;
    end
    if (o_vld && !m_axis_tready && d_new) begin
      s_tag <= d_tag;
      s_val <= d_val;
    end
  end

  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = {7'b0, o_tag.col, o_tag.row, o_val};
  assign m_axis_tlast  = o_tag.last;
  assign m_axis_tuser  = o_tag.done;

endmodule

// ----- tb/sv/heat_diffusion_stencil_pass_top_tb.sv -----
// Self-checking testbench for heat_diffusion_stencil_pass_top: streams grids of cells,
// predicts every updated cell in a scoreboard class and checks the output stream.
// Depends on hds_pkg and the RTL of the stencil block only.
module heat_diffusion_stencil_pass_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hds_pkg::*;

  localparam int MAX_N = 32;

  // One updated cell as it leaves the block.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             done;
  } cell_result_t;

  // Tracks the three line stores, the raster position and the two registers,
  // and keeps the updated cells still owed by the block in arrival order.
  class heat_step;
    logic [VAL_W-1:0] above [MAX_N];
    logic [VAL_W-1:0] middle [MAX_N];
    logic [VAL_W-1:0] incoming [MAX_N];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [GS_W-1:0] grid_reg;
    logic [PHI_W-1:0] phi_reg;
    cell_result_t expected_cells[$];
    int errors;

    function new();
      foreach (above[i]) begin
        above[i] = '0;
        middle[i] = '0;
        incoming[i] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      grid_reg = GRID_SIZE_RST;
      phi_reg = PHI_COEFF_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [PHI_W-1:0] data);
      if (idx == REG_GRID_SIZE) begin
        grid_reg = data[GS_W-1:0];
        row_pos = 0;
        col_pos = 0;
      end else if (idx == REG_PHI_COEFF) begin
        phi_reg = data;
      end
    endfunction

    // Grid size actually used: clamp to 3..32.
    function int unsigned span();
      if (grid_reg < GRID_MIN) return GRID_MIN;
      if (grid_reg > MAX_N) return MAX_N;
      return grid_reg;
    endfunction

    function logic [VAL_W-1:0] next_temp(logic [VAL_W-1:0] v, logic [VAL_W-1:0] up,
                                         logic [VAL_W-1:0] dn, logic [VAL_W-1:0] lf,
                                         logic [VAL_W-1:0] rt);
      longint lap;
      longint acc;
      lap = longint'(up) + longint'(dn) + longint'(lf) + longint'(rt) - 4 * longint'(v);
      acc = longint'(v) * 65536 + longint'(phi_reg) * lap + 32768;
      if (acc < 0) return '0;
      acc = acc >>> 16;
      if (acc > 32767) return '1;
      return acc[VAL_W-1:0];
    endfunction

    function void push(logic [VAL_W-1:0] value, int unsigned row, int unsigned col,
                       logic last, logic done);
      cell_result_t res;
      res.value = value;
      res.row = row[POS_W-1:0];
      res.col = col[POS_W-1:0];
      res.last = last;
      res.done = done;
      expected_cells.push_back(res);
    endfunction

    function void take_cell(logic [VAL_W-1:0] v);
      int unsigned n;
      int unsigned r;
      int unsigned c;
      logic [VAL_W-1:0] val;
      n = span();
      r = row_pos;
      c = col_pos;
      if (r >= n || c >= n) begin
        r = 0;
        c = 0;
      end
      incoming[c] = v;
      // Cell above the incoming one is now complete.
      if (r >= 1) begin
        if (r == 1 || c == 0 || c == n - 1) val = middle[c];
        else val = next_temp(middle[c], above[c], incoming[c], middle[c-1], middle[c+1]);
        push(val, r - 1, c, !(c == n - 1 && r == n - 1), 1'b0);
      end
      if (c == n - 1) begin
        if (r == n - 1) begin
          // Flush the bottom row unchanged.
          for (int unsigned i = 0; i < n; i++)
            push(incoming[i], n - 1, i, i == n - 1, i == n - 1);
          row_pos = 0;
        end else begin
          above = middle;
          middle = incoming;
          row_pos = r + 1;
        end
        col_pos = 0;
      end else begin
        row_pos = r;
        col_pos = c + 1;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_cell(logic [31:0] data, logic last, logic done);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected word: expected none, actual value %0d row %0d col %0d",
                 $time, data[14:0], data[19:15], data[24:20]);
        return;
      end
      want = expected_cells.pop_front();
      compare_field("new_value", want.value, data[14:0]);
      compare_field("out_row", want.row, data[19:15]);
      compare_field("out_col", want.col, data[24:20]);
      compare_field("last_of_run", want.last, last);
      compare_field("grid_done", want.done, done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [PHI_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [14:0] cell_value
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [14:0] new_value, [19:15] out_row, [24:20] out_col
  logic m_axis_tlast;               // last_of_run
  logic m_axis_tuser;               // grid_done

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  heat_step next_grid = new();

  heat_diffusion_stencil_pass_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Receiver: drop tready at random according to the current stall rate.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every word accepted on the output side against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      next_grid.check_cell(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Hard limit on the run: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Mode 0: no idling; 1: sender idles; 2: receiver stalls; 3: both, lightly.
  task automatic set_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 58;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct = 15;
        recv_stall_pct = 15;
      end
    endcase
  endtask

  // Write one register; hold the enable for exactly one edge.
  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [PHI_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    next_grid.write_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one cell, with random idle cycles ahead of it, and wait for the handshake.
  task automatic send_cell(input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, v};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    next_grid.take_cell(v);
  endtask

  // 3x3 grid: uniform border around one center cell.
  task automatic send_ring(input logic [VAL_W-1:0] ring, input logic [VAL_W-1:0] center);
    for (int i = 0; i < 9; i++) send_cell(i == 4 ? center : ring);
  endtask

  // Style 0: full range; style 1: a narrow warm band; both also give 0 and 32767 one time in four.
  function automatic logic [VAL_W-1:0] pick_cell(input int style);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: begin
        if (style == 1) return VAL_W'(16000 + $urandom_range(0, 700));
        return VAL_W'($urandom_range(0, 32767));
      end
    endcase
  endfunction

  task automatic stream_cells(input int count, input int style);
    for (int i = 0; i < count; i++) send_cell(pick_cell(style));
  endtask

  // Drain: lower tvalid, wait for every owed word, then let the pipeline and any
  // first-row words finish before the next register write.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (next_grid.expected_cells.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    int phase;
    int random_cells;
    int cur_n;
    int gs;
    int cells;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: smallest grid with phi far above the stable limit, so the center
    // saturates high with a cold center and clamps to zero with a hot one.
    set_mode(0);
    cfg_write(REG_GRID_SIZE, PHI_W'(3));
    cfg_write(REG_PHI_COEFF, '1);
    send_ring('1, '0);
    send_ring('0, '1);
    // Partial pass, then restart it by writing grid_size below.
    send_cell(15'h5555);
    send_cell(15'h2AAA);
    send_cell('0);
    send_cell('1);
    settle();

    // Oversized grid_size clamps to the largest grid; phi at its stable limit.
    // Stream three full rows and a few cells, and leave the pass open.
    cfg_write(REG_GRID_SIZE, PHI_W'(63));
    cfg_write(REG_PHI_COEFF, PHI_W'(16384));
    stream_cells(3 * MAX_N + 4, 0);
    settle();

    // grid_size of zero clamps to 3; phi zero passes every cell through.
    set_mode(1);
    cfg_write(REG_GRID_SIZE, PHI_W'(0));
    cfg_write(REG_PHI_COEFF, '0);
    stream_cells(18, 1);
    settle();
    cur_n = 3;

    // Random phases: small grids, random phi, junk in the unused data bits of
    // grid_size writes, and now and then a pass left open across a phase.
    phase = 0;
    random_cells = 0;
    while (random_cells < 130) begin
      set_mode(phase % 4);
      if ($urandom_range(0, 3) != 0) begin
        gs = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 8);
        if ($urandom_range(0, 7) == 0) gs = $urandom_range(0, 2);
        cfg_write(REG_GRID_SIZE, {9'($urandom_range(0, 511)), 6'(gs)});
        cur_n = (gs < 3) ? 3 : gs;
      end
      if ($urandom_range(0, 4) == 0)
        cfg_write(REG_PHI_COEFF, PHI_W'($urandom_range(16385, 32767)));
      else
        cfg_write(REG_PHI_COEFF, PHI_W'($urandom_range(0, 16384)));
      cells = $urandom_range(1, 3) * cur_n * cur_n;
      if ($urandom_range(0, 2) == 0) cells += $urandom_range(1, cur_n * cur_n - 1);
      // Cap the phase so the whole run stays near its cell budget.
      if (cells > 170 - random_cells) cells = 170 - random_cells;
      stream_cells(cells, $urandom_range(0, 1));
      random_cells += cells;
      settle();
      phase++;
    end

    if (next_grid.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
